### rtl/core/bca_pkg.sv
// Shared types and constants for the bitmap chunk allocator.
// Used by bitmap_chunk_allocator and the testbench; depends on nothing.
`default_nettype none

package bca_pkg;

   // Fixed field widths of the command and result items.
   localparam int IDX_W     = 8;
   localparam int USED_W    = 9;
   localparam int CHUNK_W   = 16;
   localparam int ADDR_W    = 32;
   localparam int PROD_W    = IDX_W + CHUNK_W;
   localparam int INDEX_CAP = 256;

   // Configuration port.
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 32;
   localparam int CHUNK_SIZE_RST = 16;

   // Default pool geometry.
   localparam int DEF_GROUPS = 8;
   localparam int DEF_SLOTS  = 32;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHUNK_SIZE = 1'b0,
      CSR_BASE_ADDR  = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD
   } state_type;

endpackage

`default_nettype wire

### rtl/core/bitmap_chunk_allocator.sv
// Top level of the bitmap chunk allocator: sequencer, scan datapath and config registers.
// Depends on bca_pkg, bca_map_ram and bca_slot_find.
`default_nettype none

// A command item is taken when start is high and busy is low; busy stays high until the
// result strobe. An allocate walks the group maps one group per cycle from group 0, reading
// up to GROUPS groups (8 by default); when it finds a free slot it passes through ST_MUL and
// ST_ADD before rsp_valid, and when every group is full it goes from ST_SCAN to ST_ADD. The
// map memory's single read port sets that pace. A free walks the groups the same way until it
// reaches the group holding the index, then goes to ST_ADD, and a free with an index beyond
// the pool goes straight from ST_IDLE to ST_ADD. The result is presented for exactly one
// cycle on rsp_valid and cannot be held off, so the receiver must capture it then. A new
// command may be issued in the cycle the result is shown. Configuration writes are always
// accepted (csr_ready is tied high) and must only be made while busy is low.
module bitmap_chunk_allocator #(
   parameter int GROUPS          = bca_pkg::DEF_GROUPS,
   parameter int SLOTS_PER_GROUP = bca_pkg::DEF_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Command channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_cmd,
   input  wire logic [bca_pkg::IDX_W-1:0]         req_free_index,
   // Result channel
   output logic                                   rsp_valid,
   output logic      [1:0]                        rsp_status,
   output logic      [bca_pkg::IDX_W-1:0]         rsp_chunk_index,
   output logic      [bca_pkg::ADDR_W-1:0]        rsp_chunk_addr,
   output logic      [bca_pkg::USED_W-1:0]        rsp_used_count,
   // Configuration channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bca_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W  = bca_pkg::IDX_W;
   localparam int USED_W = bca_pkg::USED_W;
   localparam int ADDR_W = bca_pkg::ADDR_W;
   localparam int PROD_W = bca_pkg::PROD_W;
   localparam int POOL   = (GROUPS * SLOTS_PER_GROUP < bca_pkg::INDEX_CAP) ?
                           GROUPS * SLOTS_PER_GROUP : bca_pkg::INDEX_CAP;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SW     = $clog2(SLOTS_PER_GROUP);
   localparam int SUM_W  = $clog2(bca_pkg::INDEX_CAP + SLOTS_PER_GROUP) + 1;

   bca_pkg::state_type state_ff, state_in;

   logic                          cmd_ff, cmd_in;
   logic [IDX_W-1:0]              fidx_ff, fidx_in;
   logic [GW-1:0]                 g_ff, g_in;
   logic [IDX_W-1:0]              base_ff, base_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   bca_pkg::status_type           status_ff, status_in;
   logic                          ok_ff, ok_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [USED_W-1:0]             used_ff, used_in;
   logic [bca_pkg::CHUNK_W-1:0]   chunk_size_ff;
   logic [ADDR_W-1:0]             base_addr_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   bca_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]              rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]             rsp_addr_ff, rsp_addr_in;
   logic [USED_W-1:0]             rsp_used_ff, rsp_used_in;

   logic [SLOTS_PER_GROUP-1:0]    row;
   logic [SLOTS_PER_GROUP-1:0]    pad_mask;
   logic [SLOTS_PER_GROUP-1:0]    row_eff;
   logic [SLOTS_PER_GROUP-1:0]    wr_row;
   logic                          wr_en;
   logic                          found;
   logic [SW-1:0]                 slot;
   logic [SW-1:0]                 free_slot;
   logic [SUM_W-1:0]              base_next;
   logic                          free_hit;
   logic                          free_set;
   logic                          scan_end;
   logic                          free_oor;

   // Occupancy map memory, read at the group the sequencer will look at next.
   bca_map_ram #(
      .DEPTH (GROUPS),
      .WIDTH (SLOTS_PER_GROUP),
      .AW    (GW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (g_ff),
      .wr_data (wr_row),
      .rd_addr (g_in),
      .rd_data (row)
   );

   // Slots whose chunk index lies beyond the pool look occupied.
   always_comb begin
      for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
         pad_mask[s] = (SUM_W'(base_ff) + SUM_W'(s)) >= SUM_W'(POOL);
      end
   end

   assign row_eff = row | pad_mask;

   bca_slot_find #(
      .SLOTS (SLOTS_PER_GROUP),
      .SW    (SW)
   ) u_find (
      .row   (row_eff),
      .found (found),
      .slot  (slot)
   );

   // Group window bound shared by both commands, and the compares each command uses.
   assign base_next = SUM_W'(base_ff) + SUM_W'(SLOTS_PER_GROUP);
   assign scan_end  = base_next >= SUM_W'(POOL);
   assign free_hit  = SUM_W'(fidx_ff) < base_next;
   assign free_slot = SW'(fidx_ff - base_ff);
   assign free_set  = row[free_slot];
   assign free_oor  = {1'b0, req_free_index} >= USED_W'(POOL);

   // Row update: set the chosen slot on allocate, clear the named slot on free.
   always_comb begin
      if (cmd_ff == bca_pkg::CMD_ALLOC) begin
         wr_row = row | (SLOTS_PER_GROUP'(1) << slot);
         wr_en  = (state_ff == bca_pkg::ST_SCAN) && found;
      end else begin
         wr_row = row & ~(SLOTS_PER_GROUP'(1) << free_slot);
         wr_en  = (state_ff == bca_pkg::ST_SCAN) && free_hit && free_set;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bca_pkg::ST_IDLE: begin
            if (start) begin
               if ((req_cmd == bca_pkg::CMD_FREE) && free_oor) begin
                  state_in = bca_pkg::ST_ADD;
               end else begin
                  state_in = bca_pkg::ST_SCAN;
               end
            end
         end
         bca_pkg::ST_SCAN: begin
            if (cmd_ff == bca_pkg::CMD_ALLOC) begin
               if (found) begin
                  state_in = bca_pkg::ST_MUL;
               end else if (scan_end) begin
                  state_in = bca_pkg::ST_ADD;
               end
            end else if (free_hit) begin
               state_in = bca_pkg::ST_ADD;
            end
         end
         bca_pkg::ST_MUL: state_in = bca_pkg::ST_ADD;
         bca_pkg::ST_ADD: state_in = bca_pkg::ST_IDLE;
         default:         state_in = bca_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls per state.
   always_comb begin
      cmd_in        = cmd_ff;
      fidx_in       = fidx_ff;
      g_in          = '0;
      base_in       = base_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      ok_in         = ok_ff;
      prod_in       = prod_ff;
      used_in       = used_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;
      unique case (state_ff)
         bca_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in  = req_cmd;
               fidx_in = req_free_index;
               base_in = '0;
               idx_in  = '0;
               ok_in   = 1'b0;
               if ((req_cmd == bca_pkg::CMD_FREE) && free_oor) begin
                  status_in = bca_pkg::STATUS_RANGE;
               end else begin
                  status_in = bca_pkg::STATUS_OK;
               end
            end
         end
         bca_pkg::ST_SCAN: begin
            if (cmd_ff == bca_pkg::CMD_ALLOC) begin
               if (found) begin
                  idx_in  = IDX_W'(base_ff + IDX_W'(slot));
                  ok_in   = 1'b1;
                  used_in = USED_W'(used_ff + USED_W'(1));
               end else if (scan_end) begin
                  status_in = bca_pkg::STATUS_FULL;
               end else begin
                  g_in    = GW'(g_ff + GW'(1));
                  base_in = IDX_W'(base_next);
               end
            end else if (free_hit) begin
               if (free_set && (used_ff != '0)) begin
                  used_in = USED_W'(used_ff - USED_W'(1));
               end
            end else begin
               g_in    = GW'(g_ff + GW'(1));
               base_in = IDX_W'(base_next);
            end
         end
         bca_pkg::ST_MUL: begin
            prod_in = PROD_W'(idx_ff) * PROD_W'(chunk_size_ff);
         end
         bca_pkg::ST_ADD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_index_in  = ok_ff ? idx_ff : '0;
            rsp_addr_in   = ok_ff ? (base_addr_ff + ADDR_W'(prod_ff)) : '0;
            rsp_used_in   = used_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bca_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      fidx_ff       <= fidx_in;
      g_ff          <= g_in;
      base_ff       <= base_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      ok_ff         <= ok_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= bca_pkg::CHUNK_W'(bca_pkg::CHUNK_SIZE_RST);
         base_addr_ff  <= '0;
      end else if (csr_valid) begin
         unique case (bca_pkg::csr_type'(csr_index))
            bca_pkg::CSR_CHUNK_SIZE: chunk_size_ff <= csr_wdata[bca_pkg::CHUNK_W-1:0];
            bca_pkg::CSR_BASE_ADDR:  base_addr_ff  <= csr_wdata[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign busy            = (state_ff != bca_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chunk_index = rsp_index_ff;
   assign rsp_chunk_addr  = rsp_addr_ff;
   assign rsp_used_count  = rsp_used_ff;

endmodule

`default_nettype wire

### rtl/core/bca_map_ram.sv
// Occupancy map memory: one row per group, one bit per slot.
// Rows carry valid bits so that a row never written reads as all free; depends on nothing.
`default_nettype none

module bca_map_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32,
   parameter int AW    = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [WIDTH-1:0] rd_q_ff;
   logic             rd_valid_ff;

   // Row storage and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Valid bits clear at reset so the whole pool starts free.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

### rtl/core/bca_slot_find.sv
// Lowest-free-slot search over one occupancy row.
// Pure combinational priority encoder; no package dependencies.
`default_nettype none

module bca_slot_find #(
   parameter int SLOTS = 32,
   parameter int SW    = 5
) (
   input  wire logic [SLOTS-1:0] row,
   output logic                  found,
   output logic      [SW-1:0]    slot
);

   // Scan from the top so the lowest clear bit wins.
   always_comb begin
      found = ~&row;
      slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!row[i]) begin
            slot = SW'(i);
         end
      end
   end

endmodule

`default_nettype wire

### bench/bitmap_chunk_allocator_test.sv
// Self-checking testbench for the bitmap chunk allocator: directed script, then random phases.
// Depends on bca_pkg and the bitmap_chunk_allocator top level under rtl/core.

module bitmap_chunk_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W       = bca_pkg::IDX_W;
   localparam int ADDR_W      = bca_pkg::ADDR_W;
   localparam int USED_W      = bca_pkg::USED_W;
   localparam int CHUNK_W     = bca_pkg::CHUNK_W;
   localparam int CSR_IDX_W   = bca_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = bca_pkg::CSR_DATA_W;
   localparam int GROUP_COUNT = bca_pkg::DEF_GROUPS;
   localparam int SLOT_COUNT  = bca_pkg::DEF_SLOTS;
   localparam int POOL_CHUNKS = (GROUP_COUNT * SLOT_COUNT < bca_pkg::INDEX_CAP) ?
                                GROUP_COUNT * SLOT_COUNT : bca_pkg::INDEX_CAP;
   localparam int QUIET_LIMIT = 1000;
   localparam int SCRIPT_LEN  = 20;

   // One result item as the allocator reports it.
   typedef struct packed {
      bca_pkg::status_type   status;
      logic [IDX_W-1:0]      chunk_index;
      logic [ADDR_W-1:0]     chunk_addr;
      logic [USED_W-1:0]     used_count;
   } alloc_result_type;

   // One row of the directed script: a command item or a register write.
   typedef struct packed {
      logic                  is_csr;
      bca_pkg::cmd_type      cmd;
      logic [IDX_W-1:0]      arg;
      bca_pkg::csr_type      reg_sel;
      logic [CSR_DATA_W-1:0] wdata;
      logic                  typed;
      alloc_result_type      want;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_cmd;
   logic [IDX_W-1:0]        req_free_index;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic [IDX_W-1:0]        rsp_chunk_index;
   logic [ADDR_W-1:0]       rsp_chunk_addr;
   logic [USED_W-1:0]       rsp_used_count;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // Shadow copy of the pool and its registers.
   logic [SLOT_COUNT-1:0]   occupancy [GROUP_COUNT];
   logic [USED_W-1:0]       used_total;
   logic [CHUNK_W-1:0]      cfg_chunk_size;
   logic [ADDR_W-1:0]       cfg_base;

   alloc_result_type        expected_q [$];
   script_row_type          script [SCRIPT_LEN];
   int unsigned             issued_count = 0;
   int unsigned             done_count = 0;
   int unsigned             full_results = 0;
   int unsigned             fail_count = 0;
   int unsigned             quiet_cycles = 0;
   int unsigned             burst_left = 0;
   bit                      gaps_enabled = 1'b1;

   bitmap_chunk_allocator u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_free_index  (req_free_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_chunk_index (rsp_chunk_index),
      .rsp_chunk_addr  (rsp_chunk_addr),
      .rsp_used_count  (rsp_used_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // First-fit allocation and release over the shadow pool; updates the shadow state.
   function automatic alloc_result_type predict_command(bca_pkg::cmd_type cmd,
                                                        logic [IDX_W-1:0] arg);
      alloc_result_type r;
      int unsigned      chunk;
      r = '0;
      if (cmd == bca_pkg::CMD_ALLOC) begin
         r.status = bca_pkg::STATUS_FULL;
         for (chunk = 0; chunk < POOL_CHUNKS; chunk++) begin
            if (!occupancy[chunk / SLOT_COUNT][chunk % SLOT_COUNT]) begin
               occupancy[chunk / SLOT_COUNT][chunk % SLOT_COUNT] = 1'b1;
               used_total = used_total + 1'b1;
               r.status = bca_pkg::STATUS_OK;
               r.chunk_index = chunk[IDX_W-1:0];
               r.chunk_addr = cfg_base + ADDR_W'(chunk) * ADDR_W'(cfg_chunk_size);
               break;
            end
         end
      end else if (int'(arg) >= POOL_CHUNKS) begin
         r.status = bca_pkg::STATUS_RANGE;
      end else if (occupancy[arg / SLOT_COUNT][arg % SLOT_COUNT]) begin
         // Releasing a chunk that is already free changes nothing.
         occupancy[arg / SLOT_COUNT][arg % SLOT_COUNT] = 1'b0;
         if (used_total != 0) used_total = used_total - 1'b1;
      end
      r.used_count = used_total;
      return r;
   endfunction

   // Mostly names a chunk that is in use, so that frees really release something.
   function automatic logic [IDX_W-1:0] pick_release_index();
      int unsigned probe;
      int unsigned step;
      int unsigned chunk;
      probe = $urandom_range(0, 255);
      if (used_total != 0 && $urandom_range(0, 3) != 0) begin
         for (step = 0; step < POOL_CHUNKS; step++) begin
            chunk = (probe + step) % POOL_CHUNKS;
            if (occupancy[chunk / SLOT_COUNT][chunk % SLOT_COUNT]) return IDX_W'(chunk);
         end
      end
      return IDX_W'(probe);
   endfunction

   // Presents one command item, waits for it to be taken, and records its expectation.
   // Start stays high after acceptance unless a gap in the burst follows.
   task automatic issue_command(bca_pkg::cmd_type cmd, logic [IDX_W-1:0] arg, bit typed,
                                alloc_result_type want);
      alloc_result_type predicted;
      int unsigned      gap;
      start <= 1'b1;
      req_cmd <= cmd;
      req_free_index <= arg;
      do @(posedge clock); while (busy);
      predicted = predict_command(cmd, arg);
      if (predicted.status == bca_pkg::STATUS_FULL) full_results++;
      expected_q.push_back(typed ? want : predicted);
      issued_count++;
      gap = 0;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops start and waits until every outstanding item has produced its result.
   task automatic quiesce();
      start <= 1'b0;
      while (done_count < issued_count) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write of a group.
   task automatic csr_write(bca_pkg::csr_type sel, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         bca_pkg::CSR_CHUNK_SIZE: cfg_chunk_size = data[CHUNK_W-1:0];
         bca_pkg::CSR_BASE_ADDR:  cfg_base = data;
         default: ;
      endcase
   endtask

   task automatic set_pool_config(logic [CHUNK_W-1:0] size, logic [ADDR_W-1:0] base);
      quiesce();
      csr_write(bca_pkg::CSR_CHUNK_SIZE, CSR_DATA_W'(size));
      csr_write(bca_pkg::CSR_BASE_ADDR, base);
      csr_valid <= 1'b0;
   endtask

   // Random traffic: alloc_pct percent allocations, the rest frees. The phase runs for
   // item_count items and keeps going, up to twice that many, until full_target
   // pool-full results have come.
   task automatic run_phase(int unsigned alloc_pct, int unsigned item_count, bit gaps_on,
                            int unsigned full_target);
      int unsigned sent;
      int unsigned full_start;
      gaps_enabled = gaps_on;
      sent = 0;
      full_start = full_results;
      while (sent < item_count ||
             (full_results - full_start < full_target && sent < 2 * item_count)) begin
         if ($urandom_range(1, 100) <= alloc_pct)
            issue_command(bca_pkg::CMD_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0, '0);
         else
            issue_command(bca_pkg::CMD_FREE, pick_release_index(), 1'b0, '0);
         sent++;
      end
   endtask

   // Result checker: each strobed item is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         done_count <= done_count + 1;
         if (expected_q.size() == 0) begin
            $error("result item with nothing expected: status %0d index %0d",
                   rsp_status, rsp_chunk_index);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_chunk_index !== want.chunk_index) begin
               $error("chunk_index: expected %0d, got %0d", want.chunk_index, rsp_chunk_index);
               fail_count++;
            end
            if (rsp_chunk_addr !== want.chunk_addr) begin
               $error("chunk_addr: expected %h, got %h", want.chunk_addr, rsp_chunk_addr);
               fail_count++;
            end
            if (rsp_used_count !== want.used_count) begin
               $error("used_count: expected %0d, got %0d", want.used_count, rsp_used_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bitmap_chunk_allocator_test: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int i;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= bca_pkg::CMD_ALLOC;
      req_free_index <= '0;
      csr_valid <= 1'b0;
      csr_index <= bca_pkg::CSR_CHUNK_SIZE;
      csr_wdata <= '0;
      foreach (occupancy[g]) occupancy[g] = '0;
      used_total = '0;
      cfg_chunk_size = CHUNK_W'(bca_pkg::CHUNK_SIZE_RST);
      cfg_base = '0;

      // Directed script. Reset registers first, then address wrap at the extremes, a zero
      // chunk size, repeated and never-used frees, and reuse of the lowest free slot.
      script = '{
         '{1'b0, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd1}},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'hFF, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd1, 32'd16, 9'd2}},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'hAA, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd2, 32'd32, 9'd3}},
         '{1'b0, bca_pkg::CMD_FREE, 8'd1, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd2}},
         '{1'b0, bca_pkg::CMD_FREE, 8'd1, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd2}},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'h55, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd1, 32'd16, 9'd3}},
         '{1'b0, bca_pkg::CMD_FREE, 8'd255, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd3}},
         '{1'b0, bca_pkg::CMD_FREE, 8'd0, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd2}},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'hFF, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd0, 32'd0, 9'd3}},
         '{1'b1, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0000_FFFF, 1'b0, '0},
         '{1'b1, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_BASE_ADDR, 32'hFFFF_FFFF, 1'b0, '0},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd3, 32'h0002_FFFC, 9'd4}},
         '{1'b1, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0000_0000, 1'b0, '0},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd4, 32'hFFFF_FFFF, 9'd5}},
         '{1'b1, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0000_0001, 1'b0, '0},
         '{1'b1, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_BASE_ADDR, 32'h0000_0000, 1'b0, '0},
         '{1'b0, bca_pkg::CMD_ALLOC, 8'h00, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b1,
           '{bca_pkg::STATUS_OK, 8'd5, 32'd5, 9'd6}},
         '{1'b0, bca_pkg::CMD_FREE, 8'd128, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b0, '0},
         '{1'b0, bca_pkg::CMD_FREE, 8'd127, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b0, '0},
         '{1'b0, bca_pkg::CMD_FREE, 8'd5, bca_pkg::CSR_CHUNK_SIZE, 32'h0, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register writes wait for the allocator to go idle; a run of writes shares one valid.
      for (i = 0; i < SCRIPT_LEN; i++) begin
         if (script[i].is_csr) begin
            if (i == 0 || !script[i-1].is_csr) quiesce();
            csr_write(script[i].reg_sel, script[i].wdata);
            if (i == SCRIPT_LEN - 1 || !script[i+1].is_csr) csr_valid <= 1'b0;
         end else begin
            issue_command(script[i].cmd, script[i].arg, script[i].typed, script[i].want);
         end
      end

      // Fill the pool until several allocations have been refused, then drain and mix.
      set_pool_config(CHUNK_W'($urandom_range(1, 65535)), $urandom);
      run_phase(90, 280, 1'b1, 8);
      set_pool_config(16'hFFFF, 32'hFFFF_FFFF);
      run_phase(30, 80, 1'b0, 0);
      set_pool_config(16'h0000, $urandom);
      run_phase(50, 70, 1'b1, 0);
      set_pool_config(16'h0001, 32'h0000_0000);
      run_phase(60, 70, 1'b1, 0);
      set_pool_config(CHUNK_W'($urandom_range(1, 65535)), $urandom);
      run_phase(75, 40, 1'b1, 0);

      quiesce();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("bitmap_chunk_allocator_test: PASS");
      else
         $display("bitmap_chunk_allocator_test: FAIL");
      $finish;
   end

endmodule
